// ===== rtl/nghash_pkg.sv =====
// Package for the n-gram frequency hash table: sizes, codes and the
// sequencer state type. Used by the top level and the testbench; depends on nothing.
package nghash_pkg;

	localparam int MAX_TOKENS   = 4;
	localparam int BUCKETS      = 1021;
	localparam int POOL_ENTRIES = 4096;

	localparam int ENTRY_W  = $clog2(POOL_ENTRIES);
	localparam int PTR_W    = ENTRY_W + 1;
	localparam int BUCKET_W = $clog2(BUCKETS);
	localparam int TOKEN_W  = 32;
	localparam int KEY_W    = MAX_TOKENS * TOKEN_W;
	localparam int COUNT_W  = 32;
	localparam int HASH_W   = 32;
	localparam int SIZE_W   = 3;

	localparam logic [PTR_W-1:0]    NIL_ENTRY   = PTR_W'(POOL_ENTRIES);
	localparam logic [HASH_W-1:0]   HASH_SEED   = 32'd5381;
	localparam logic [BUCKET_W:0]   BUCKETS_V   = (BUCKET_W+1)'(BUCKETS);
	localparam logic [BUCKET_W-1:0] LAST_BUCKET = BUCKET_W'(BUCKETS - 1);
	// 2^BUCKET_W modulo the bucket count, used to fold the high hash bits.
	localparam logic [HASH_W-1:0]   FOLD_MUL    = HASH_W'((1 << BUCKET_W) - BUCKETS);

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_DELETE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_MOD,
		ST_HEAD,
		ST_HEADD,
		ST_LOOK,
		ST_CMP,
		ST_HIT,
		ST_MISS,
		ST_FRD,
		ST_ALLOC,
		ST_LINK,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/nghash_ram.sv =====
// Generic single write port, single read port RAM with a registered read.
// Depends on nothing.
module nghash_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/ngram_frequency_hash_table.sv =====
// Top level of the n-gram frequency hash table: sequencer, hash and modulo
// unit, and the five table memories. Depends on nghash_pkg and nghash_ram.
//
// Channel   Dir  Handshake            Word contents
// s_*       in   s_tvalid / s_tready  operation, token_0..3, add_count
// m_*       out  m_tvalid / m_tready  found, count_value, status, stored_keys
// cfg_*     in   cfg_we               ngram_size
//
// One word goes through the idle state in which it is taken, hashing (n
// tokens, one byte per cycle), folding the hash down to the bucket
// remainder, the bucket head read, a compare for each chain entry, then
// the finish (miss check, free-list read, allocation, tail link, done).
// After reset the bucket heads are wiped, one per cycle; s_tready stays
// low meanwhile. s_tready is high only while the sequencer is idle. A
// finished result waits in the output register while the next word is
// taken in; the sequencer stalls at its end only if that register is
// still full.
module ngram_frequency_hash_table (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [1:0] operation, [33:2] token_0, [65:34] token_1, [97:66] token_2,
	// [129:98] token_3, [161:130] add_count, [167:162] zero
	input  logic [167:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [0] found, [32:1] count_value, [33] status, [46:34] stored_keys, [47] zero
	output logic [47:0]  m_tdata,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_wdata
);

	localparam int EW = nghash_pkg::ENTRY_W;
	localparam int PW = nghash_pkg::PTR_W;
	localparam int BW = nghash_pkg::BUCKET_W;
	localparam int KW = nghash_pkg::KEY_W;
	localparam int CW = nghash_pkg::COUNT_W;

	nghash_pkg::state_t state_q, state_d;

	logic [2:0]          size_q;
	logic [2:0]          n_q;
	nghash_pkg::op_t     op_q;
	logic [KW-1:0]       key_q;
	logic [KW-1:0]       key_mask_q;
	logic [CW-1:0]       add_q;
	logic [31:0]         h_q;
	logic [3:0]          bi_q;
	logic [BW-1:0]       r_q;
	logic [BW-1:0]       clr_q;
	logic [PW-1:0]       e_q;
	logic [PW-1:0]       prev_q;
	logic [PW-1:0]       nxt_q;
	logic [CW-1:0]       cnt_q;
	logic [EW-1:0]       ne_q;
	logic [PW-1:0]       keys_q;
	logic [PW-1:0]       peak_q;
	logic                res_found_q;
	logic [CW-1:0]       res_count_q;
	logic                res_status_q;
	logic                out_valid_q;
	logic [47:0]         out_data_q;

	// Memory ports.
	logic          head_we, next_we, key_we, cnt_we, free_we;
	logic [BW-1:0] head_waddr;
	logic [PW-1:0] head_wdata, head_rdata;
	logic [EW-1:0] next_waddr, ent_raddr, free_waddr, free_raddr;
	logic [PW-1:0] next_wdata, next_rdata;
	logic [KW-1:0] key_rdata;
	logic [CW-1:0] cnt_wdata, cnt_rdata;
	logic [EW-1:0] free_rdata;
	logic [EW-1:0] cnt_waddr;

	// Effective key length: 0 acts as 1, anything above 4 as 4.
	logic [2:0] n_eff;
	always_comb begin
		n_eff = size_q;
		if (size_q == 3'd0) begin
			n_eff = 3'd1;
		end else if (size_q > 3'(nghash_pkg::MAX_TOKENS)) begin
			n_eff = 3'(nghash_pkg::MAX_TOKENS);
		end
	end

	logic [KW-1:0] in_mask;
	always_comb begin
		for (int t = 0; t < nghash_pkg::MAX_TOKENS; t++) begin
			in_mask[t*32 +: 32] = (3'(t) < n_eff) ? '1 : '0;
		end
	end

	// Shared hash step: h = h*33 ^ h>>27 ^ byte, with h*33 as shift and add.
	logic [7:0]  hbyte;
	logic [31:0] h_next;
	logic [3:0]  last_bi;
	assign hbyte   = key_q[{bi_q, 3'b000} +: 8];
	assign h_next  = ({h_q[26:0], 5'b00000} + h_q) ^ (h_q >> 27) ^ {24'd0, hbyte};
	assign last_bi = 4'({n_q, 2'b00} - 5'd1);

	// Bucket remainder: the bits above the low BW are worth FOLD_MUL each
	// modulo the bucket count, so they are folded back in once per cycle
	// until the value fits in BW bits; one compare and subtract finishes it.
	logic [31:0] h_hi;
	logic [31:0] h_fold;
	logic [BW:0] r_low;
	logic [BW:0] r_sub;
	assign h_hi   = 32'(h_q[31:BW]);
	assign h_fold = h_hi * nghash_pkg::FOLD_MUL + 32'(h_q[BW-1:0]);
	assign r_low  = {1'b0, h_q[BW-1:0]};
	assign r_sub  = r_low - nghash_pkg::BUCKETS_V;

	logic key_match;
	assign key_match = ((key_rdata ^ key_q) & key_mask_q) == '0;

	logic fresh;
	assign fresh = (keys_q == peak_q);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			nghash_pkg::ST_CLEAR: begin
				if (clr_q == nghash_pkg::LAST_BUCKET) state_d = nghash_pkg::ST_IDLE;
			end
			nghash_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					if (s_tdata[1:0] == nghash_pkg::OP_NONE) state_d = nghash_pkg::ST_DONE;
					else state_d = nghash_pkg::ST_HASH;
				end
			end
			nghash_pkg::ST_HASH: begin
				if (bi_q == last_bi) state_d = nghash_pkg::ST_MOD;
			end
			nghash_pkg::ST_MOD: begin
				if (h_q[31:BW] == '0) state_d = nghash_pkg::ST_HEAD;
			end
			nghash_pkg::ST_HEAD:  state_d = nghash_pkg::ST_HEADD;
			nghash_pkg::ST_HEADD: state_d = nghash_pkg::ST_LOOK;
			nghash_pkg::ST_LOOK: begin
				if (e_q[PW-1]) state_d = nghash_pkg::ST_MISS;
				else state_d = nghash_pkg::ST_CMP;
			end
			nghash_pkg::ST_CMP: begin
				if (key_match) state_d = nghash_pkg::ST_HIT;
				else state_d = nghash_pkg::ST_LOOK;
			end
			nghash_pkg::ST_HIT: state_d = nghash_pkg::ST_DONE;
			nghash_pkg::ST_MISS: begin
				if (op_q != nghash_pkg::OP_ADD || keys_q[PW-1]) state_d = nghash_pkg::ST_DONE;
				else if (fresh) state_d = nghash_pkg::ST_ALLOC;
				else state_d = nghash_pkg::ST_FRD;
			end
			nghash_pkg::ST_FRD: state_d = nghash_pkg::ST_ALLOC;
			nghash_pkg::ST_ALLOC: begin
				if (prev_q[PW-1]) state_d = nghash_pkg::ST_DONE;
				else state_d = nghash_pkg::ST_LINK;
			end
			nghash_pkg::ST_LINK: state_d = nghash_pkg::ST_DONE;
			nghash_pkg::ST_DONE: begin
				if (!out_valid_q || m_tready) state_d = nghash_pkg::ST_IDLE;
			end
			default: state_d = nghash_pkg::ST_CLEAR;
		endcase
	end

	// Memory controls and handshake outputs.
	always_comb begin
		head_we    = 1'b0;
		head_waddr = r_q;
		head_wdata = nxt_q;
		next_we    = 1'b0;
		next_waddr = ne_q;
		next_wdata = nghash_pkg::NIL_ENTRY;
		key_we     = 1'b0;
		cnt_we     = 1'b0;
		cnt_waddr  = e_q[EW-1:0];
		cnt_wdata  = cnt_q + add_q;
		free_we    = 1'b0;
		free_waddr = EW'(PW'(nghash_pkg::POOL_ENTRIES) - keys_q);
		free_raddr = EW'(PW'(nghash_pkg::POOL_ENTRIES - 1) - keys_q);
		ent_raddr  = e_q[EW-1:0];
		s_tready   = 1'b0;
		unique case (state_q)
			nghash_pkg::ST_CLEAR: begin
				head_we    = 1'b1;
				head_waddr = clr_q;
				head_wdata = nghash_pkg::NIL_ENTRY;
			end
			nghash_pkg::ST_IDLE: s_tready = 1'b1;
			nghash_pkg::ST_HIT: begin
				if (op_q == nghash_pkg::OP_ADD) begin
					cnt_we = 1'b1;
				end else if (op_q == nghash_pkg::OP_DELETE) begin
					if (prev_q[PW-1]) begin
						head_we = 1'b1;
					end else begin
						next_we    = 1'b1;
						next_waddr = prev_q[EW-1:0];
						next_wdata = nxt_q;
					end
					free_we = 1'b1;
				end
			end
			nghash_pkg::ST_ALLOC: begin
				key_we     = 1'b1;
				cnt_we     = 1'b1;
				cnt_waddr  = ne_q;
				cnt_wdata  = add_q;
				next_we    = 1'b1;
				head_we    = prev_q[PW-1];
				head_wdata = {1'b0, ne_q};
			end
			nghash_pkg::ST_LINK: begin
				next_we    = 1'b1;
				next_waddr = prev_q[EW-1:0];
				next_wdata = {1'b0, ne_q};
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nghash_pkg::ST_CLEAR;
			size_q      <= 3'd1;
			clr_q       <= '0;
			keys_q      <= '0;
			peak_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) size_q <= cfg_wdata;
			if (state_q == nghash_pkg::ST_CLEAR) clr_q <= clr_q + BW'(1);
			if (state_q == nghash_pkg::ST_HIT && op_q == nghash_pkg::OP_DELETE) begin
				keys_q <= keys_q - PW'(1);
			end
			if (state_q == nghash_pkg::ST_ALLOC) begin
				keys_q <= keys_q + PW'(1);
				if (fresh) peak_q <= peak_q + PW'(1);
			end
			if (state_q == nghash_pkg::ST_DONE && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			nghash_pkg::ST_IDLE: begin
				op_q         <= nghash_pkg::op_t'(s_tdata[1:0]);
				key_q        <= s_tdata[129:2] & in_mask;
				key_mask_q   <= in_mask;
				add_q        <= s_tdata[161:130];
				n_q          <= n_eff;
				h_q          <= nghash_pkg::HASH_SEED;
				bi_q         <= '0;
				res_found_q  <= 1'b0;
				res_count_q  <= '0;
				res_status_q <= 1'b0;
			end
			nghash_pkg::ST_HASH: begin
				h_q  <= h_next;
				bi_q <= bi_q + 4'd1;
			end
			nghash_pkg::ST_MOD: begin
				if (h_q[31:BW] != '0) begin
					h_q <= h_fold;
				end else begin
					r_q <= r_sub[BW] ? r_low[BW-1:0] : r_sub[BW-1:0];
				end
			end
			nghash_pkg::ST_HEADD: begin
				e_q    <= head_rdata;
				prev_q <= nghash_pkg::NIL_ENTRY;
			end
			nghash_pkg::ST_CMP: begin
				cnt_q <= cnt_rdata;
				nxt_q <= next_rdata;
				if (!key_match) begin
					prev_q <= e_q;
					e_q    <= next_rdata;
				end
			end
			nghash_pkg::ST_HIT: begin
				res_found_q <= 1'b1;
				res_count_q <= (op_q == nghash_pkg::OP_ADD) ? cnt_q + add_q : cnt_q;
			end
			nghash_pkg::ST_MISS: begin
				ne_q <= keys_q[EW-1:0];
				if (op_q == nghash_pkg::OP_ADD && keys_q[PW-1]) res_status_q <= 1'b1;
			end
			nghash_pkg::ST_FRD: ne_q <= free_rdata;
			nghash_pkg::ST_ALLOC: res_count_q <= add_q;
			nghash_pkg::ST_DONE: begin
				// The output register is only reloaded once it is free.
				if (!out_valid_q || m_tready) begin
					out_data_q <= {1'b0, keys_q, res_status_q, res_count_q, res_found_q};
				end
			end
			default: ;
		endcase
	end

	nghash_ram #(.WIDTH(PW), .DEPTH(nghash_pkg::BUCKETS)) u_head (
		.clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
		.raddr(r_q), .rdata(head_rdata)
	);

	nghash_ram #(.WIDTH(KW), .DEPTH(nghash_pkg::POOL_ENTRIES)) u_key (
		.clk(clk), .we(key_we), .waddr(ne_q), .wdata(key_q),
		.raddr(ent_raddr), .rdata(key_rdata)
	);

	nghash_ram #(.WIDTH(CW), .DEPTH(nghash_pkg::POOL_ENTRIES)) u_count (
		.clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
		.raddr(ent_raddr), .rdata(cnt_rdata)
	);

	nghash_ram #(.WIDTH(PW), .DEPTH(nghash_pkg::POOL_ENTRIES)) u_next (
		.clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
		.raddr(ent_raddr), .rdata(next_rdata)
	);

	nghash_ram #(.WIDTH(EW), .DEPTH(nghash_pkg::POOL_ENTRIES)) u_free (
		.clk(clk), .we(free_we), .waddr(free_waddr), .wdata(e_q[EW-1:0]),
		.raddr(free_raddr), .rdata(free_rdata)
	);

`ifndef SYNTH
	// The key count never passes the pool size nor the high-water mark.
	assert property (@(posedge clk) disable iff (!arst_n)
		keys_q <= peak_q && peak_q <= PW'(nghash_pkg::POOL_ENTRIES))
		else $error("key count out of range");

	// A new result is loaded only from the final sequencer state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == nghash_pkg::ST_DONE))
		else $error("result loaded outside of the done state");

	// An entry is allocated only for an add whose key was not found.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == nghash_pkg::ST_ALLOC |-> op_q == nghash_pkg::OP_ADD && e_q[PW-1])
		else $error("allocation without a missed add");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the n-gram frequency hash table.
// Depends on nghash_pkg and the ngram_frequency_hash_table RTL only.
`timescale 1ns / 100ps

module tb_top;

	// One expected or observed result word, highest bits first as in m_tdata.
	typedef struct packed {
		logic [12:0] stored_keys;
		logic        status;
		logic [31:0] count_value;
		logic        found;
	} tally_t;

	// One directed stimulus row; has_exp marks rows with a typed-in result.
	typedef struct {
		nghash_pkg::op_t op;
		logic [31:0]     tok [4];
		logic [31:0]     amount;
		bit              has_exp;
		tally_t          exp;
	} row_t;

	localparam int unsigned NIL_IDX = nghash_pkg::POOL_ENTRIES;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [167:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [47:0]  m_tdata;
	logic         cfg_we = 1'b0;
	logic [2:0]   cfg_wdata = 3'd1;

	ngram_frequency_hash_table uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// Shadow copy of the table with the same buckets, chains and free stack,
	// so that keys stored under another size are found exactly when the
	// block would find them.
	logic [2:0]  shadow_size;
	int unsigned shadow_head [nghash_pkg::BUCKETS];
	logic [31:0] shadow_key [nghash_pkg::POOL_ENTRIES][4];
	logic [31:0] shadow_count [nghash_pkg::POOL_ENTRIES];
	int unsigned shadow_next [nghash_pkg::POOL_ENTRIES];
	int unsigned shadow_free [nghash_pkg::POOL_ENTRIES];
	int unsigned shadow_total;
	tally_t      pending_tallies [$];
	int          errors = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	logic [31:0] used_tokens [$];

	task automatic reset_shadow();
		shadow_size = 3'd1;
		shadow_total = 0;
		for (int i = 0; i < nghash_pkg::BUCKETS; i++)
			shadow_head[i] = NIL_IDX;
		for (int i = 0; i < nghash_pkg::POOL_ENTRIES; i++) begin
			for (int t = 0; t < 4; t++)
				shadow_key[i][t] = 32'd0;
			shadow_count[i] = 32'd0;
			shadow_next[i] = NIL_IDX;
			shadow_free[i] = NIL_IDX - 1 - i;
		end
	endtask

	function automatic int unsigned key_width();
		if (shadow_size == 3'd0)
			return 1;
		if (shadow_size > 3'd4)
			return 4;
		return shadow_size;
	endfunction

	function automatic logic [31:0] key_hash(logic [31:0] key [4], int unsigned n);
		logic [31:0] h;
		h = 32'd5381;
		for (int t = 0; t < 4; t++)
			if (t < n)
				for (int b = 0; b < 4; b++)
					h = (h * 32'd33) ^ (h >> 27) ^ {24'd0, key[t][8*b +: 8]};
		return h;
	endfunction

	function automatic tally_t predict_tally(nghash_pkg::op_t op, logic [31:0] tok [4],
			logic [31:0] amount);
		logic [31:0] key [4];
		tally_t r;
		int unsigned n, bucket, e, prev, ne, tail, steps;
		bit same;
		n = key_width();
		r = '0;
		for (int t = 0; t < 4; t++)
			key[t] = (t < n) ? tok[t] : 32'd0;
		if (op != nghash_pkg::OP_NONE) begin
			bucket = key_hash(key, n) % nghash_pkg::BUCKETS;
			prev = NIL_IDX;
			e = shadow_head[bucket];
			steps = 0;
			while (e < NIL_IDX && steps < NIL_IDX) begin
				same = 1'b1;
				for (int t = 0; t < 4; t++)
					if (t < n && shadow_key[e][t] != key[t])
						same = 1'b0;
				if (same)
					break;
				prev = e;
				e = shadow_next[e];
				steps++;
			end
			if (steps >= NIL_IDX)
				e = NIL_IDX;
			if (e < NIL_IDX) begin
				r.found = 1'b1;
				case (op)
					nghash_pkg::OP_ADD: begin
						shadow_count[e] = shadow_count[e] + amount;
						r.count_value = shadow_count[e];
					end
					nghash_pkg::OP_LOOKUP: r.count_value = shadow_count[e];
					default: begin
						r.count_value = shadow_count[e];
						if (prev == NIL_IDX)
							shadow_head[bucket] = shadow_next[e];
						else
							shadow_next[prev] = shadow_next[e];
						shadow_next[e] = NIL_IDX;
						if (shadow_total > 0) begin
							shadow_free[NIL_IDX - shadow_total] = e;
							shadow_total--;
						end
					end
				endcase
			end else if (op == nghash_pkg::OP_ADD) begin
				if (shadow_total >= NIL_IDX) begin
					r.status = 1'b1;
				end else begin
					ne = shadow_free[NIL_IDX - shadow_total - 1];
					for (int t = 0; t < 4; t++)
						shadow_key[ne][t] = key[t];
					shadow_count[ne] = amount;
					shadow_next[ne] = NIL_IDX;
					shadow_total++;
					r.count_value = amount;
					if (shadow_head[bucket] == NIL_IDX) begin
						shadow_head[bucket] = ne;
					end else begin
						tail = shadow_head[bucket];
						while (shadow_next[tail] < NIL_IDX)
							tail = shadow_next[tail];
						shadow_next[tail] = ne;
					end
				end
			end
		end
		r.stored_keys = shadow_total[12:0];
		return r;
	endfunction

	// Drives one word and waits for its acceptance; the prediction is made
	// at acceptance so the shadow table stays in word order. s_tvalid is
	// left high on return and dropped by the next idle cycle or drain.
	task automatic send_word(nghash_pkg::op_t op, logic [31:0] tok [4],
			logic [31:0] amount, bit has_exp, tally_t exp);
		tally_t p;
		while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tdata <= {6'd0, amount, tok[3], tok[2], tok[1], tok[0], op};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		p = predict_tally(op, tok, amount);
		if (has_exp && p != exp) begin
			$display("%0t: table row disagrees with predictor exp=%h got=%h",
				$time, exp, p);
			errors++;
		end
		pending_tallies.push_back(p);
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_tallies.size() != 0)
			@(negedge clk);
		// Every word yields a result, but allow a few idle cycles anyway.
		repeat (8)
			@(negedge clk);
	endtask

	task automatic write_size(logic [2:0] v);
		drain_results();
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		shadow_size = v;
	endtask

	// Receiver side: random stalls, field-by-field compare on acceptance.
	always @(negedge clk) begin
		m_tready <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
	end

	always @(posedge clk) begin
		tally_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[46:0];
			if (pending_tallies.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, got);
				errors++;
			end else begin
				want = pending_tallies.pop_front();
				if (got.found !== want.found) begin
					$display("%0t: found exp=%0d got=%0d", $time, want.found, got.found);
					errors++;
				end
				if (got.count_value !== want.count_value) begin
					$display("%0t: count_value exp=%h got=%h", $time,
						want.count_value, got.count_value);
					errors++;
				end
				if (got.status !== want.status) begin
					$display("%0t: status exp=%0d got=%0d", $time, want.status, got.status);
					errors++;
				end
				if (got.stored_keys !== want.stored_keys) begin
					$display("%0t: stored_keys exp=%0d got=%0d", $time,
						want.stored_keys, got.stored_keys);
					errors++;
				end
			end
		end
	end

	// Picks a token: often one seen before so that keys collide and repeat.
	function automatic logic [31:0] pick_token();
		logic [31:0] v;
		if (used_tokens.size() > 0 && $urandom_range(99, 0) < 70)
			return used_tokens[$urandom_range(used_tokens.size() - 1, 0)];
		case ($urandom_range(5, 0))
			0: v = 32'h0000_0000;
			1: v = 32'hFFFF_FFFF;
			2: v = 32'h8000_0000;
			3: v = 32'h7FFF_FFFF;
			default: v = $urandom();
		endcase
		if (used_tokens.size() < 12)
			used_tokens.push_back(v);
		return v;
	endfunction

	task automatic random_words(int count);
		logic [31:0] tok [4];
		logic [31:0] amount;
		nghash_pkg::op_t op;
		int r;
		for (int i = 0; i < count; i++) begin
			for (int t = 0; t < 4; t++)
				tok[t] = pick_token();
			r = $urandom_range(99, 0);
			// Adds most often so the table grows; some noise with the unused code.
			op = (r < 50) ? nghash_pkg::OP_ADD : (r < 75) ? nghash_pkg::OP_LOOKUP :
				(r < 95) ? nghash_pkg::OP_DELETE : nghash_pkg::OP_NONE;
			case ($urandom_range(3, 0))
				0: amount = 32'hFFFF_FFFF;
				1: amount = $urandom_range(3, 0);
				default: amount = $urandom();
			endcase
			send_word(op, tok, amount, 1'b0, '0);
		end
	endtask

	row_t steps [$];

	function automatic row_t mk(nghash_pkg::op_t op, logic [31:0] t0, logic [31:0] t1,
			logic [31:0] amount, bit has_exp, logic f, logic [31:0] c, logic [12:0] k);
		row_t r;
		r.op = op;
		r.tok[0] = t0;
		r.tok[1] = t1;
		r.tok[2] = ~t0;
		r.tok[3] = ~t1;
		r.amount = amount;
		r.has_exp = has_exp;
		r.exp = '{found: f, count_value: c, status: 1'b0, stored_keys: k};
		return r;
	endfunction

	initial begin
		reset_shadow();
		// Directed table, run with ngram_size 1 from reset. Tokens 1 and 3 differ
		// between rows that share token 0, so they must be ignored.
		steps.push_back(mk(nghash_pkg::OP_LOOKUP, 32'h0, 32'h1, 32'h5, 1, 0, 32'h0, 13'd0));
		steps.push_back(mk(nghash_pkg::OP_DELETE, 32'h0, 32'h1, 32'h5, 1, 0, 32'h0, 13'd0));
		steps.push_back(mk(nghash_pkg::OP_ADD, 32'h0, 32'h1, 32'hFFFF_FFFF, 1, 0,
			32'hFFFF_FFFF, 13'd1));
		// Count wraps modulo 2^32.
		steps.push_back(mk(nghash_pkg::OP_ADD, 32'h0, 32'h2, 32'h2, 1, 1, 32'h1, 13'd1));
		steps.push_back(mk(nghash_pkg::OP_LOOKUP, 32'h0, 32'h3, 32'h0, 1, 1, 32'h1, 13'd1));
		steps.push_back(mk(nghash_pkg::OP_ADD, 32'hFFFF_FFFF, 32'h0, 32'h0, 1, 0, 32'h0, 13'd2));
		steps.push_back(mk(nghash_pkg::OP_ADD, 32'h8000_0000, 32'h0, 32'h7, 1, 0, 32'h7, 13'd3));
		steps.push_back(mk(nghash_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h0, 32'h9, 1, 0, 32'h9, 13'd4));
		// Unused operation code changes nothing.
		steps.push_back(mk(nghash_pkg::OP_NONE, 32'h7FFF_FFFF, 32'h0, 32'h9, 1, 0, 32'h0, 13'd4));
		steps.push_back(mk(nghash_pkg::OP_DELETE, 32'h0, 32'h0, 32'h0, 1, 1, 32'h1, 13'd3));
		steps.push_back(mk(nghash_pkg::OP_LOOKUP, 32'h0, 32'h0, 32'h0, 1, 0, 32'h0, 13'd3));
		steps.push_back(mk(nghash_pkg::OP_ADD, 32'h0, 32'h0, 32'h4, 1, 0, 32'h4, 13'd4));
		steps.push_back(mk(nghash_pkg::OP_DELETE, 32'h8000_0000, 32'h0, 32'h0, 1, 1,
			32'h7, 13'd3));
		steps.push_back(mk(nghash_pkg::OP_ADD, 32'hA5A5_5A5A, 32'h0, 32'h5A5A_A5A5, 0, 0, 0, 0));

		repeat (8)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (steps[i])
			send_word(steps[i].op, steps[i].tok, steps[i].amount,
				steps[i].has_exp, steps[i].exp);

		// Size changes, including out-of-range codes that clamp.
		write_size(3'd4);
		random_words(60);
		write_size(3'd0);
		random_words(40);
		write_size(3'd7);
		random_words(40);

		// Sender idle and receiver stall phases over sizes 2, 3 and 1, then a run at size 4 with neither.
		write_size(3'd2);
		send_idle_pct = 51;
		random_words(120);
		// Sender holds off until every result is back.
		drain_results();
		write_size(3'd3);
		send_idle_pct = 0;
		recv_stall_pct = 51;
		random_words(120);
		write_size(3'd1);
		send_idle_pct = 26;
		recv_stall_pct = 26;
		random_words(120);
		write_size(3'd4);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_words(100);

		drain_results();
		repeat (100)
			@(negedge clk);
		if (errors == 0 && pending_tallies.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Worst case: ~620 words with stalls, plus the clearing pass; this limit
	// is far above that.
	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/nghash_pkg.sv
rtl/nghash_ram.sv
rtl/ngram_frequency_hash_table.sv
tb/tb_top.sv
